### rtl/core/qaar_pkg.sv
// Shared types and constants for the quaternion axis-angle rotation block.
// Holds the field types, the pipeline stage counts and the CORDIC arctangent table.
// No dependencies.
package qaar_pkg;

    typedef logic signed [31:0] vec_t;
    typedef logic signed [15:0] axis_t;
    typedef logic        [15:0] angle_t;
    typedef logic        [15:0] mag_t;
    typedef logic signed [31:0] unit_t;
    typedef logic signed [32:0] trig_t;
    typedef logic signed [63:0] prod_t;
    typedef logic signed [34:0] tq_t;
    typedef logic signed [32:0] rq_t;

    typedef struct packed {
        vec_t x;
        vec_t y;
        vec_t z;
        logic zero;
    } side_t;

    localparam int SQRT_STAGES = 32;
    localparam int QUOT_W      = 31;
    localparam int DIV_STAGES  = QUOT_W;
    localparam int NORM_LAT    = SQRT_STAGES + DIV_STAGES + 1;
    localparam int POST_STAGES = 7;
    localparam int ATAN_STEPS  = 24;

    localparam trig_t       CORDIC_GAIN = 33'sd652032874;
    localparam logic [30:0] HALF_PI     = 31'd1686629713;

    localparam prod_t HALF_LSB29 = 64'sd268435456;
    localparam prod_t HALF_LSB30 = 64'sd536870912;
    localparam prod_t HALF_LSB31 = 64'sd1073741824;

    localparam vec_t ROT_MAX = 32'sh7fff_ffff;
    localparam vec_t ROT_MIN = 32'sh8000_0000;

    // atan(2^-i) in Q30
    function automatic trig_t atan_q30(input logic [4:0] idx);
        trig_t r;
        unique case (idx)
            5'd0:    r = 33'sd843314856;
            5'd1:    r = 33'sd497837829;
            5'd2:    r = 33'sd263043836;
            5'd3:    r = 33'sd133525158;
            5'd4:    r = 33'sd67021686;
            5'd5:    r = 33'sd33543515;
            5'd6:    r = 33'sd16775850;
            5'd7:    r = 33'sd8388437;
            5'd8:    r = 33'sd4194282;
            5'd9:    r = 33'sd2097149;
            5'd10:   r = 33'sd1048575;
            5'd11:   r = 33'sd524287;
            5'd12:   r = 33'sd262143;
            5'd13:   r = 33'sd131071;
            5'd14:   r = 33'sd65535;
            5'd15:   r = 33'sd32767;
            5'd16:   r = 33'sd16383;
            5'd17:   r = 33'sd8191;
            5'd18:   r = 33'sd4095;
            5'd19:   r = 33'sd2047;
            5'd20:   r = 33'sd1023;
            5'd21:   r = 33'sd511;
            5'd22:   r = 33'sd255;
            5'd23:   r = 33'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/qaar_in_if.sv
// Request channel of the rotation block: valid/ready plus vector, axis and angle.
// Depends on qaar_pkg.
interface qaar_in_if
    import qaar_pkg::*;
();
    logic   valid;
    logic   ready;
    vec_t   vec_x;
    vec_t   vec_y;
    vec_t   vec_z;
    axis_t  axis_x;
    axis_t  axis_y;
    axis_t  axis_z;
    angle_t turn_angle;

    modport source (
        output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle,
        input  ready
    );
    modport sink (
        input  valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle,
        output ready
    );
endinterface

### rtl/core/qaar_out_if.sv
// Result channel of the rotation block: valid/ready plus rotated vector and flags.
// Depends on qaar_pkg.
interface qaar_out_if
    import qaar_pkg::*;
();
    logic valid;
    logic ready;
    vec_t rot_x;
    vec_t rot_y;
    vec_t rot_z;
    logic axis_zero;
    logic saturated;

    modport source (
        output valid, rot_x, rot_y, rot_z, axis_zero, saturated,
        input  ready
    );
    modport sink (
        input  valid, rot_x, rot_y, rot_z, axis_zero, saturated,
        output ready
    );
endinterface

### rtl/core/quaternion_axis_angle_rotate.sv
// Top level: rotates a Q16.16 vector about an axis by a turn fraction, p*v*conj(p).
// Depends on qaar_pkg, qaar_in_if, qaar_out_if, qaar_norm and qaar_cordic.
//
// Usage:
//   item   carries vec_x/y/z (Q16.16), axis_x/y/z (any scale) and turn_angle
//          (value/65536 of a full turn); a request is taken when valid and ready.
//   result carries rot_x/y/z (Q16.16, saturated), axis_zero and saturated.
//   Every request gives exactly one result, in order.
// Throughput: one request per cycle while no result is held unaccepted (see Stall).
// Pipeline: the axis path sets when result.valid rises, whatever TRIG_ITERATIONS
//   is: an input stage, 32 square root stages, 31 division stages, a sign stage
//   and seven product stages, 72 registers in all; the CORDIC is padded to match.
// Stall: while a result waits unaccepted the whole pipeline holds in place and
//   item.ready is low; nothing is dropped or repeated.
// Reset: clears the valid bits only; the block takes requests on the first
//   cycle after reset is released.
// A zero axis passes the vector through with axis_zero set and saturated clear.
module quaternion_axis_angle_rotate
    import qaar_pkg::*;
#(
    parameter int TRIG_ITERATIONS = 16
)
(
    input logic        clk,
    input logic        rst_n,
    qaar_in_if.sink    item,
    qaar_out_if.source result
);

    localparam int CORDIC_STEPS = (TRIG_ITERATIONS < ATAN_STEPS) ? TRIG_ITERATIONS : ATAN_STEPS;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int TRIG_DLY     = NORM_LAT - CORDIC_LAT;
    localparam int LAT          = 1 + NORM_LAT + POST_STAGES;
    localparam int ST_VEC       = NORM_LAT + 2;
    localparam int NXT [3]      = '{1, 2, 0};
    localparam int PRV [3]      = '{2, 0, 1};

    logic [LAT-1:0] valid_reg;
    logic           adv;

    // input stage
    logic [31:0] n2_reg;
    mag_t        mag_reg [3];
    logic [2:0]  neg_reg;
    angle_t      angle_reg;
    side_t       side_reg [LAT-1];
    logic [31:0] n2_next;
    mag_t        mag_next [3];
    axis_t       ax [3];
    logic signed [31:0] sq [3];

    // axis and trig results
    unit_t unit_vec [3];
    trig_t cos_raw;
    trig_t sin_raw;
    trig_t tdc_reg [TRIG_DLY];
    trig_t tds_reg [TRIG_DLY];

    // product stages
    prod_t p1_prod_reg [3];
    trig_t p1_pw_reg;
    unit_t p2_pv_reg [3];
    trig_t p2_pw_reg;
    prod_t p3_pd_reg  [3];
    prod_t p3_pwv_reg [3];
    prod_t p3_crp_reg [3];
    prod_t p3_crm_reg [3];
    unit_t p3_pv_reg  [3];
    trig_t p3_pw_reg;
    tq_t   p4_tw_reg;
    tq_t   p4_tv_reg [3];
    unit_t p4_pv_reg [3];
    trig_t p4_pw_reg;
    prod_t p5_a_reg [3];
    prod_t p5_b_reg [3];
    prod_t p5_c_reg [3];
    prod_t p5_d_reg [3];
    rq_t   p6_rv_reg [3];
    vec_t  rot_reg [3];
    logic  zero_reg;
    logic  sat_reg;

    prod_t p4_s0;
    prod_t p4_s [3];
    prod_t p6_s [3];
    vec_t  v3 [3];
    vec_t  vlast [3];
    vec_t  rot_next [3];
    logic  sat_next;

    // advance the whole pipeline unless a finished result is held
    assign adv        = !valid_reg[LAT-1] || result.ready;
    assign item.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[LAT-2:0], item.valid};
    end

    // squared axis length and component magnitudes
    always_comb
    begin
        ax[0] = item.axis_x;
        ax[1] = item.axis_y;
        ax[2] = item.axis_z;
        for (int k = 0; k < 3; k++)
        begin
            sq[k]       = 32'(ax[k]) * 32'(ax[k]);
            mag_next[k] = ax[k][15] ? mag_t'(-ax[k]) : mag_t'(ax[k]);
        end
        n2_next = $unsigned(sq[0]) + $unsigned(sq[1]) + $unsigned(sq[2]);
    end

    qaar_norm u_norm (
        .clk      (clk),
        .en       (adv),
        .n2       (n2_reg),
        .mag      (mag_reg),
        .neg      (neg_reg),
        .unit_vec (unit_vec)
    );

    qaar_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .en      (adv),
        .angle   (angle_reg),
        .cos_q30 (cos_raw),
        .sin_q30 (sin_raw)
    );

    // Hamilton product terms
    always_comb
    begin
        v3[0]    = side_reg[ST_VEC].x;
        v3[1]    = side_reg[ST_VEC].y;
        v3[2]    = side_reg[ST_VEC].z;
        vlast[0] = side_reg[LAT-2].x;
        vlast[1] = side_reg[LAT-2].y;
        vlast[2] = side_reg[LAT-2].z;
        p4_s0    = p3_pd_reg[0] + p3_pd_reg[1] + p3_pd_reg[2];
        for (int k = 0; k < 3; k++)
        begin
            p4_s[k] = p3_pwv_reg[k] + p3_crp_reg[k] - p3_crm_reg[k];
            p6_s[k] = p5_a_reg[k] - p5_b_reg[k] - p5_c_reg[k] + p5_d_reg[k];
        end
    end

    // clamp to 32 bits, or pass the vector for a zero axis
    always_comb
    begin
        sat_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if (p6_rv_reg[k][32] != p6_rv_reg[k][31])
            begin
                rot_next[k] = p6_rv_reg[k][32] ? ROT_MIN : ROT_MAX;
                sat_next    = 1'b1;
            end
            else
            begin
                rot_next[k] = p6_rv_reg[k][31:0];
            end
        end
        if (side_reg[LAT-2].zero)
        begin
            rot_next = vlast;
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // input stage and sideband line
            n2_reg      <= n2_next;
            mag_reg     <= mag_next;
            neg_reg     <= {ax[2][15], ax[1][15], ax[0][15]};
            angle_reg   <= item.turn_angle;
            side_reg[0] <= '{x: item.vec_x, y: item.vec_y, z: item.vec_z,
                             zero: (item.axis_x == '0) && (item.axis_y == '0)
                                   && (item.axis_z == '0)};
            for (int s = 1; s < LAT-1; s++)
                side_reg[s] <= side_reg[s-1];

            // align the trig results with the unit axis
            tdc_reg[0] <= cos_raw;
            tds_reg[0] <= sin_raw;
            for (int s = 1; s < TRIG_DLY; s++)
            begin
                tdc_reg[s] <= tdc_reg[s-1];
                tds_reg[s] <= tds_reg[s-1];
            end

            // p = cos + sin * u
            p1_pw_reg <= tdc_reg[TRIG_DLY-1];
            for (int k = 0; k < 3; k++)
                p1_prod_reg[k] <= prod_t'(tds_reg[TRIG_DLY-1]) * prod_t'(unit_vec[k]);
            p2_pw_reg <= p1_pw_reg;
            for (int k = 0; k < 3; k++)
                p2_pv_reg[k] <= 32'((p1_prod_reg[k] + HALF_LSB30) >>> 30);

            // t = p * (0, v)
            p3_pw_reg <= p2_pw_reg;
            p3_pv_reg <= p2_pv_reg;
            for (int k = 0; k < 3; k++)
            begin
                p3_pd_reg[k]  <= prod_t'(p2_pv_reg[k]) * prod_t'(v3[k]);
                p3_pwv_reg[k] <= prod_t'(p2_pw_reg) * prod_t'(v3[k]);
                p3_crp_reg[k] <= prod_t'(p2_pv_reg[NXT[k]]) * prod_t'(v3[PRV[k]]);
                p3_crm_reg[k] <= prod_t'(p2_pv_reg[PRV[k]]) * prod_t'(v3[NXT[k]]);
            end
            p4_pw_reg <= p3_pw_reg;
            p4_pv_reg <= p3_pv_reg;
            p4_tw_reg <= 35'((HALF_LSB29 - p4_s0) >>> 29);
            for (int k = 0; k < 3; k++)
                p4_tv_reg[k] <= 35'((p4_s[k] + HALF_LSB29) >>> 29);

            // vector part of t * conj(p)
            for (int k = 0; k < 3; k++)
            begin
                p5_a_reg[k] <= prod_t'(p4_pw_reg) * prod_t'(p4_tv_reg[k]);
                p5_b_reg[k] <= prod_t'(p4_tw_reg) * prod_t'(p4_pv_reg[k]);
                p5_c_reg[k] <= prod_t'(p4_tv_reg[NXT[k]]) * prod_t'(p4_pv_reg[PRV[k]]);
                p5_d_reg[k] <= prod_t'(p4_tv_reg[PRV[k]]) * prod_t'(p4_pv_reg[NXT[k]]);
            end
            for (int k = 0; k < 3; k++)
                p6_rv_reg[k] <= 33'((p6_s[k] + HALF_LSB31) >>> 31);

            // output register
            rot_reg  <= rot_next;
            zero_reg <= side_reg[LAT-2].zero;
            sat_reg  <= sat_next;
        end
    end

    assign result.valid     = valid_reg[LAT-1];
    assign result.rot_x     = rot_reg[0];
    assign result.rot_y     = rot_reg[1];
    assign result.rot_z     = rot_reg[2];
    assign result.axis_zero = zero_reg;
    assign result.saturated = sat_reg;

`ifndef SYNTHESIS
    // a held result must block new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !item.ready)
        else $error("request taken while a result is stalled");

    // a taken request enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> valid_reg[0])
        else $error("accepted request lost at the input stage");

    // a zero axis is a pass-through and never clamps
    a_zero_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.axis_zero |-> !result.saturated)
        else $error("saturation flagged on a zero-axis result");

    // a clamp leaves at least one component at a limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated |->
            (result.rot_x == ROT_MAX || result.rot_x == ROT_MIN ||
             result.rot_y == ROT_MAX || result.rot_y == ROT_MIN ||
             result.rot_z == ROT_MAX || result.rot_z == ROT_MIN))
        else $error("saturation flagged with no component at a limit");
`endif

endmodule

### rtl/core/qaar_norm.sv
// Axis normalizer: pipelined square root of the squared length, then three
// pipelined restoring dividers giving the unit axis in Q2.30. Depends on qaar_pkg.
module qaar_norm
    import qaar_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] n2,
    input  mag_t        mag [3],
    input  logic [2:0]  neg,
    output unit_t       unit_vec [3]
);

    // square root stages, one result bit each
    logic [63:0] srad_reg  [SQRT_STAGES];
    logic [34:0] srem_reg  [SQRT_STAGES];
    logic [31:0] sroot_reg [SQRT_STAGES];
    mag_t        smag_reg  [SQRT_STAGES][3];
    logic [2:0]  sneg_reg  [SQRT_STAGES];
    logic [63:0] srad_next  [SQRT_STAGES];
    logic [34:0] srem_next  [SQRT_STAGES];
    logic [31:0] sroot_next [SQRT_STAGES];

    // divider stages, one quotient bit each
    logic [31:0]       drem_reg  [DIV_STAGES][3];
    logic [QUOT_W-1:0] dquo_reg  [DIV_STAGES][3];
    logic [30:0]       dlow_reg  [DIV_STAGES];
    logic [31:0]       dlen_reg  [DIV_STAGES];
    logic [2:0]        dneg_reg  [DIV_STAGES];
    logic [31:0]       drem_next [DIV_STAGES][3];
    logic [QUOT_W-1:0] dquo_next [DIV_STAGES][3];
    logic [30:0]       dlow_next [DIV_STAGES];

    unit_t unit_reg  [3];
    unit_t unit_next [3];

    // advance the square root one bit per stage
    always_comb
    begin
        for (int s = 0; s < SQRT_STAGES; s++)
        begin
            logic [63:0] rad_in;
            logic [34:0] rem_in;
            logic [31:0] root_in;
            logic [34:0] rem_t;
            logic [34:0] trial;
            if (s == 0)
            begin
                rad_in  = {n2, 32'd0};
                rem_in  = '0;
                root_in = '0;
            end
            else
            begin
                rad_in  = srad_reg[s-1];
                rem_in  = srem_reg[s-1];
                root_in = sroot_reg[s-1];
            end
            rem_t = {rem_in[32:0], rad_in[63:62]};
            trial = {1'b0, root_in, 2'b01};
            if (rem_t >= trial)
            begin
                srem_next[s]  = rem_t - trial;
                sroot_next[s] = {root_in[30:0], 1'b1};
            end
            else
            begin
                srem_next[s]  = rem_t;
                sroot_next[s] = {root_in[30:0], 1'b0};
            end
            srad_next[s] = {rad_in[61:0], 2'b00};
        end
    end

    // advance the three dividers one quotient bit per stage
    always_comb
    begin
        for (int d = 0; d < DIV_STAGES; d++)
        begin
            logic [30:0] low_in;
            logic [31:0] len_in;
            logic [32:0] rem_t;
            if (d == 0)
            begin
                low_in = sroot_reg[SQRT_STAGES-1][31:1];
                len_in = sroot_reg[SQRT_STAGES-1];
            end
            else
            begin
                low_in = dlow_reg[d-1];
                len_in = dlen_reg[d-1];
            end
            for (int k = 0; k < 3; k++)
            begin
                logic [31:0]       rem_in;
                logic [QUOT_W-1:0] quo_in;
                if (d == 0)
                begin
                    rem_in = {1'b0, smag_reg[SQRT_STAGES-1][k], 15'd0};
                    quo_in = '0;
                end
                else
                begin
                    rem_in = drem_reg[d-1][k];
                    quo_in = dquo_reg[d-1][k];
                end
                rem_t = {rem_in, low_in[30]};
                if (rem_t >= {1'b0, len_in})
                begin
                    drem_next[d][k] = 32'(rem_t - {1'b0, len_in});
                    dquo_next[d][k] = {quo_in[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    drem_next[d][k] = rem_t[31:0];
                    dquo_next[d][k] = {quo_in[QUOT_W-2:0], 1'b0};
                end
            end
            dlow_next[d] = {low_in[29:0], 1'b0};
        end
        // restore the sign of each component
        for (int k = 0; k < 3; k++)
        begin
            if (dneg_reg[DIV_STAGES-1][k])
                unit_next[k] = -unit_t'({1'b0, dquo_reg[DIV_STAGES-1][k]});
            else
                unit_next[k] = unit_t'({1'b0, dquo_reg[DIV_STAGES-1][k]});
        end
    end

    // hold every stage while the pipeline is stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < SQRT_STAGES; s++)
            begin
                srad_reg[s]  <= srad_next[s];
                srem_reg[s]  <= srem_next[s];
                sroot_reg[s] <= sroot_next[s];
                if (s == 0)
                begin
                    smag_reg[s] <= mag;
                    sneg_reg[s] <= neg;
                end
                else
                begin
                    smag_reg[s] <= smag_reg[s-1];
                    sneg_reg[s] <= sneg_reg[s-1];
                end
            end
            for (int d = 0; d < DIV_STAGES; d++)
            begin
                drem_reg[d] <= drem_next[d];
                dquo_reg[d] <= dquo_next[d];
                dlow_reg[d] <= dlow_next[d];
                if (d == 0)
                begin
                    dlen_reg[d] <= sroot_reg[SQRT_STAGES-1];
                    dneg_reg[d] <= sneg_reg[SQRT_STAGES-1];
                end
                else
                begin
                    dlen_reg[d] <= dlen_reg[d-1];
                    dneg_reg[d] <= dneg_reg[d-1];
                end
            end
            unit_reg <= unit_next;
        end
    end

    assign unit_vec = unit_reg;

endmodule

### rtl/core/qaar_cordic.sv
// Pipelined rotation-mode CORDIC giving cos and sin of the half angle in Q30.
// A seed register, one micro-rotation per stage, then an output register. Depends on qaar_pkg.
module qaar_cordic
    import qaar_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic   clk,
    input  logic   en,
    input  angle_t angle,
    output trig_t  cos_q30,
    output trig_t  sin_q30
);

    trig_t x_reg    [STEPS+1];
    trig_t y_reg    [STEPS+1];
    trig_t z_reg    [STEPS+1];
    logic  quad_reg [STEPS+1];
    trig_t x_next   [STEPS+1];
    trig_t y_next   [STEPS+1];
    trig_t z_next   [STEPS+1];
    trig_t cos_reg;
    trig_t sin_reg;
    trig_t cos_next;
    trig_t sin_next;
    logic [45:0] zprod;

    // seed with the gain, rotate by each arctangent in turn
    always_comb
    begin
        zprod     = 46'(angle[14:0]) * 46'(HALF_PI);
        x_next[0] = CORDIC_GAIN;
        y_next[0] = '0;
        z_next[0] = {2'b00, zprod[45:15]};
        for (int i = 0; i < STEPS; i++)
        begin
            if (!z_reg[i][32])
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - atan_q30(5'(i));
            end
            else
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + atan_q30(5'(i));
            end
        end
        // second quadrant of the half angle
        if (quad_reg[STEPS])
        begin
            cos_next = -y_reg[STEPS];
            sin_next = x_reg[STEPS];
        end
        else
        begin
            cos_next = x_reg[STEPS];
            sin_next = y_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= STEPS; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
                if (i == 0)
                    quad_reg[i] <= angle[15];
                else
                    quad_reg[i] <= quad_reg[i-1];
            end
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_q30 = cos_reg;
    assign sin_q30 = sin_reg;

endmodule
